>>> rtl/longest_equal_run_grid_top_assert.svh
// Assertion macros for the longest equal run grid block.
// Included by the top level; each macro expands to one concurrent assertion.
`ifndef LONGEST_EQUAL_RUN_GRID_TOP_ASSERT_SVH
`define LONGEST_EQUAL_RUN_GRID_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LERG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lerg: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LERG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lerg: next-cycle check failed");

`endif

>>> rtl/lerg_pkg.sv
// Shared types, widths and the run counter helper for the run grid block.
// No dependencies.
package lerg_pkg;

   localparam int ValueW = 32;
   localparam int RunW   = 4;
   localparam logic [RunW-1:0] RunMax = 4'd15;
   localparam logic [RunW-1:0] RunOne = 4'd1;

   typedef logic signed [ValueW-1:0] value_type;
   typedef logic [RunW-1:0]          run_type;

   // One line buffer entry: the element and the runs that end on it.
   typedef struct packed {
      value_type value;
      run_type   col_run;
      run_type   diag_run;
      run_type   anti_run;
   } line_entry_type;

   // Neighbors of the current element taken from the row above.
   typedef struct packed {
      line_entry_type up;
      line_entry_type up_right;
      line_entry_type up_left;
   } neighbor_type;

   // Grid border flags of the current element.
   typedef struct packed {
      logic has_up;
      logic has_left;
      logic has_right;
   } border_type;

   typedef struct packed {
      run_type horiz;
      run_type vert;
      run_type diag;
      run_type anti;
   } run_set_type;

   // Extend a run on a match, saturating; restart at one otherwise.
   function automatic run_type bump(input logic match, input run_type prev);
      run_type result;
      if (!match) begin
         result = RunOne;
      end else if (prev == RunMax) begin
         result = RunMax;
      end else begin
         result = prev + RunOne;
      end
      return result;
   endfunction

endpackage

>>> rtl/lerg_if.sv
// Valid/ready channel interfaces for the run grid block.
// Depends on lerg_pkg for payload widths.
interface lerg_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [lerg_pkg::ValueW-1:0] cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink   (input valid, input cell_value, output ready);
endinterface

interface lerg_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lerg_pkg::RunW-1:0]  longest_run;

   modport source (output valid, output longest_run, input ready);
   modport sink   (input valid, input longest_run, output ready);
endinterface

>>> rtl/lerg_line_buffer.sv
// One-row line buffer as a shift line of SIDE+1 entries with fixed taps.
// Depends on lerg_pkg for the entry and neighbor types.
module lerg_line_buffer #(
   parameter int SIDE = 8
) (
   input  logic                     clock,
   input  logic                     shift_en,
   input  lerg_pkg::line_entry_type entry_in,
   output lerg_pkg::neighbor_type   taps
);
   import lerg_pkg::*;

   // Index k holds the element accepted k+1 transactions ago.
   line_entry_type line_ff [SIDE+1];

   always_ff @(posedge clock) begin
      if (shift_en) begin
         line_ff[0] <= entry_in;
         for (int i = 1; i <= SIDE; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign taps.up       = line_ff[SIDE-1];
   assign taps.up_right = line_ff[SIDE-2];
   assign taps.up_left  = line_ff[SIDE];

endmodule

>>> rtl/lerg_run_calc.sv
// Run lengths for one element from its neighbors, and the updated best run.
// Depends on lerg_pkg for types and the bump helper.
module lerg_run_calc (
   input  lerg_pkg::value_type    cell_value,
   input  lerg_pkg::value_type    left_value,
   input  lerg_pkg::run_type      row_run,
   input  lerg_pkg::neighbor_type taps,
   input  lerg_pkg::border_type   border,
   input  logic                   anti_en,
   input  lerg_pkg::run_type      best_in,
   output lerg_pkg::run_set_type  runs,
   output lerg_pkg::run_type      best_out
);
   import lerg_pkg::*;

   run_type best_hv;
   run_type best_hvd;

   always_comb begin
      runs.horiz = bump(border.has_left && (cell_value == left_value), row_run);
      runs.vert  = bump(border.has_up && (cell_value == taps.up.value), taps.up.col_run);
      runs.diag  = bump(border.has_up && border.has_left &&
                        (cell_value == taps.up_left.value), taps.up_left.diag_run);
      // Last column has no upper-right neighbor: restart.
      if (border.has_right) begin
         runs.anti = bump(border.has_up && (cell_value == taps.up_right.value),
                          taps.up_right.anti_run);
      end else begin
         runs.anti = RunOne;
      end
   end

   always_comb begin
      best_hv  = (runs.horiz > best_in) ? runs.horiz : best_in;
      best_hv  = (runs.vert > best_hv) ? runs.vert : best_hv;
      best_hvd = (runs.diag > best_hv) ? runs.diag : best_hv;
      if (anti_en && (runs.anti > best_hvd)) begin
         best_out = runs.anti;
      end else begin
         best_out = best_hvd;
      end
   end

endmodule

>>> rtl/longest_equal_run_grid_top.sv
// Longest equal run grid: top level with input register, run logic and result register.
// Depends on lerg_pkg, lerg_if, lerg_line_buffer, lerg_run_calc and the assertion header.
//
// Usage: send a SIDE x SIDE grid of signed 32-bit values on req_chan in row-major
// order, one element per transaction. After the last element of each grid, one
// transaction on rsp_chan carries the length of the longest run of equal values
// found along rows, columns and down-right diagonals (and down-left diagonals when
// the csr bit is set). Run counts saturate at 15.
// Throughput: one element per cycle unless rsp_chan stalls as below; the element register
// and the run logic take a new element every cycle since the line buffer updates in the
// same cycle. The result is valid from the edge at which the last element leaves the
// element register.
// A stall on rsp_chan holds the block only when a grid completes while the previous
// result is still waiting; the element register then holds and req_chan.ready drops.
// Reset: positions, best run, valid flags and the csr bit clear; the next element
// starts a new grid. Write csr only while no transaction is in flight.
`include "longest_equal_run_grid_top_assert.svh"

module longest_equal_run_grid_top #(
   parameter int SIDE = 8
) (
   input  logic        clock,
   input  logic        reset,
   lerg_req_if.sink    req_chan,
   lerg_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import lerg_pkg::*;

   localparam int PosW      = (SIDE > 2) ? $clog2(SIDE) : 1;
   localparam int RunCapInt = (SIDE < 15) ? SIDE : 15;

   logic            in_valid_ff, in_valid_in;
   value_type       in_value_ff;
   logic [PosW-1:0] col_ff, col_in;
   logic [PosW-1:0] row_ff, row_in;
   run_type         best_ff, best_in;
   value_type       left_value_ff;
   run_type         row_run_ff;
   logic            anti_en_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   run_type         longest_run_ff;

   logic            is_last;
   logic            advance;
   border_type      border;
   neighbor_type    taps;
   run_set_type     runs;
   run_type         best_next;
   line_entry_type  new_entry;

   assign border.has_up    = (row_ff != '0);
   assign border.has_left  = (col_ff != '0);
   assign border.has_right = (col_ff != PosW'(SIDE-1));
   assign is_last          = !border.has_right && (row_ff == PosW'(SIDE-1));

   // Hold the element only when its grid result cannot be placed.
   assign advance = in_valid_ff && !(is_last && rsp_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   lerg_line_buffer #(
      .SIDE (SIDE)
   ) u_line (
      .clock    (clock),
      .shift_en (advance),
      .entry_in (new_entry),
      .taps     (taps)
   );

   lerg_run_calc u_calc (
      .cell_value (in_value_ff),
      .left_value (left_value_ff),
      .row_run    (row_run_ff),
      .taps       (taps),
      .border     (border),
      .anti_en    (anti_en_ff),
      .best_in    (best_ff),
      .runs       (runs),
      .best_out   (best_next)
   );

   assign new_entry.value    = in_value_ff;
   assign new_entry.col_run  = runs.vert;
   assign new_entry.diag_run = runs.diag;
   assign new_entry.anti_run = runs.anti;

   always_comb begin
      in_valid_in  = in_valid_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
      if (advance) begin
         if (border.has_right) begin
            col_in  = col_ff + PosW'(1);
            best_in = best_next;
         end else begin
            col_in = '0;
            if (is_last) begin
               row_in       = '0;
               best_in      = '0;
               rsp_valid_in = 1'b1;
            end else begin
               row_in  = row_ff + PosW'(1);
               best_in = best_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         anti_en_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            anti_en_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_value_ff <= req_chan.cell_value;
      end
      if (advance) begin
         left_value_ff <= in_value_ff;
         row_run_ff    <= runs.horiz;
      end
      if (advance && is_last) begin
         longest_run_ff <= best_next;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.longest_run = longest_run_ff;

   `LERG_ASSERT_NEXT(a_last_posts_result, clock, reset, advance && is_last, rsp_valid_ff)
   `LERG_ASSERT_NEXT(a_last_wraps_position, clock, reset, advance && is_last,
      (col_ff == '0) && (row_ff == '0) && (best_ff == '0))
   `LERG_ASSERT_NOW(a_stall_only_when_full, clock, reset, in_valid_ff && !advance,
      rsp_valid_ff && is_last)
   `LERG_ASSERT_NOW(a_result_in_range, clock, reset, rsp_valid_ff,
      (longest_run_ff != '0) && (longest_run_ff <= RunW'(RunCapInt)))

endmodule

>>> test/tb.sv
// Testbench for longest_equal_run_grid_top: random and directed grids against a local predictor.
// Depends on lerg_pkg, the lerg_req_if / lerg_rsp_if interfaces and the top level.
`timescale 1ns / 1ps

module tb;
   import lerg_pkg::*;

   localparam int GridSide  = 8;
   localparam int GridCells = GridSide * GridSide;
   localparam int GridCount = 29;
   localparam int Phases    = 4;
   localparam int HalfPeriod = 10;
   localparam longint TimeoutNs = 64'd10_000_000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   lerg_req_if req_bus ();
   lerg_rsp_if rsp_bus ();

   longest_equal_run_grid_top #(
      .SIDE (GridSide)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Stimulus and expectation stores
   value_type cell_stream[$];
   value_type pending_cells[$];
   run_type   expected_runs[$];

   int  mismatches = 0;
   bit  req_fire = 0;
   int  sender_idle_pct = 0;
   int  receiver_idle_pct = 0;
   int  calm_left = 0;

   // Grid predictor state
   bit        anti_on;
   value_type prev_cell;
   run_type   horiz_len;
   value_type above_cell[GridSide];
   run_type   vert_len[GridSide];
   run_type   diag_len[GridSide];
   run_type   anti_len[GridSide];
   value_type corner_cell;
   run_type   corner_diag;
   run_type   grid_best;
   int        col_idx;
   int        row_idx;

   always #HalfPeriod clock = ~clock;

   function automatic run_type extend_run(input bit match, input run_type prior);
      if (!match) begin
         return run_type'(1);
      end
      return (prior == RunMax) ? RunMax : run_type'(prior + 1);
   endfunction

   // Advance one element; returns 1 with the grid's longest run on its last element.
   function automatic bit advance_grid(input value_type elem, output run_type longest);
      bit        up_ok;
      bit        left_ok;
      bit        right_ok;
      value_type old_above;
      run_type   old_diag;
      run_type   h;
      run_type   vt;
      run_type   d;
      run_type   a;
      up_ok     = row_idx != 0;
      left_ok   = col_idx != 0;
      right_ok  = col_idx != GridSide - 1;
      old_above = above_cell[col_idx];
      old_diag  = diag_len[col_idx];
      longest   = '0;

      h  = extend_run(left_ok && elem == prev_cell, horiz_len);
      vt = extend_run(up_ok && elem == old_above, vert_len[col_idx]);
      d  = extend_run(up_ok && left_ok && elem == corner_cell, corner_diag);
      if (right_ok) begin
         a = extend_run(up_ok && elem == above_cell[col_idx + 1], anti_len[col_idx + 1]);
      end else begin
         a = run_type'(1);
      end

      if (h > grid_best) grid_best = h;
      if (vt > grid_best) grid_best = vt;
      if (d > grid_best) grid_best = d;
      if (anti_on && a > grid_best) grid_best = a;

      // hold the upper-left neighbor before its entry is overwritten
      corner_cell        = old_above;
      corner_diag        = old_diag;
      prev_cell          = elem;
      horiz_len          = h;
      above_cell[col_idx] = elem;
      vert_len[col_idx]  = vt;
      diag_len[col_idx]  = d;
      anti_len[col_idx]  = a;

      if (right_ok) begin
         col_idx++;
         return 0;
      end
      col_idx = 0;
      if (row_idx != GridSide - 1) begin
         row_idx++;
         return 0;
      end
      row_idx   = 0;
      longest   = grid_best;
      grid_best = '0;
      return 1;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: mismatch: %s", $realtime, msg);
      end
   endtask

   // Monitor: sample both channels at the rising edge
   always @(posedge clock) begin : monitor
      run_type new_best;
      run_type want_run;
      if (reset) begin
         req_fire    = 0;
         anti_on     = 0;
         prev_cell   = '0;
         horiz_len   = '0;
         corner_cell = '0;
         corner_diag = '0;
         grid_best   = '0;
         col_idx     = 0;
         row_idx     = 0;
         for (int i = 0; i < GridSide; i++) begin
            above_cell[i] = '0;
            vert_len[i]   = '0;
            diag_len[i]   = '0;
            anti_len[i]   = '0;
         end
      end else begin
         req_fire = req_bus.valid && req_bus.ready;
         if (csr_write_enable) begin
            anti_on = csr_write_data;
         end
         if (req_fire) begin
            if (advance_grid(req_bus.cell_value, new_best)) begin
               expected_runs.push_back(new_best);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_runs.size() == 0) begin
               note_mismatch($sformatf("unexpected result longest_run=%0d",
                                       rsp_bus.longest_run));
            end else begin
               want_run = expected_runs.pop_front();
               if (rsp_bus.longest_run !== want_run) begin
                  note_mismatch($sformatf("longest_run expected %0d, got %0d",
                                          want_run, rsp_bus.longest_run));
               end
            end
         end
      end
   end

   // Driver: change inputs at the falling edge
   always @(negedge clock) begin : driver
      bit calm;
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         // occasional stretches with no idling on either side
         if (calm_left > 0) begin
            calm_left--;
         end else if ($urandom_range(0, 199) == 0) begin
            calm_left = $urandom_range(20, 80);
         end
         calm = calm_left > 0;
         if (!req_bus.valid || req_fire) begin
            if (pending_cells.size() != 0
                && (calm || $urandom_range(0, 99) >= sender_idle_pct)) begin
               req_bus.valid      <= 1'b1;
               req_bus.cell_value <= pending_cells.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= calm || $urandom_range(0, 99) >= receiver_idle_pct;
      end
   end

   task automatic write_csr(input bit value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Wait until the block has drained, then let its pipeline settle
   task automatic wait_quiet();
      do begin
         @(negedge clock);
      end while (pending_cells.size() != 0 || req_bus.valid || expected_runs.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin : stimulus
      value_type directed[24] = '{
         32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
         32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0000, -32'sd1,
         -32'sd1,        32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
         32'sh8000_0000, 32'sh8000_0000, -32'sd1,        32'sh0000_0000,
         32'sh0000_0000, -32'sd1,        32'sh7fff_ffff, 32'sh7fff_ffff,
         32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001, -32'sd1
      };
      int        send_pct[Phases]  = '{30, 66, 0, 0};
      int        recv_pct[Phases]  = '{66, 30, 0, 0};
      bit        anti_cfg[Phases]  = '{1'b1, 1'b0, 1'b1, 1'b0};
      int        phase_end[Phases] = '{560, 1150, 1720, GridCount * GridCells};
      value_type pool[GridSide];
      value_type elem;
      int        kind;
      int        k;
      int        start;

      clock              = 1'b0;
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.cell_value = '0;
      rsp_bus.ready      = 1'b0;

      // Build the element stream: mostly patterned grids with equal-value runs
      for (int g = 0; g < GridCount; g++) begin
         kind = $urandom_range(0, 7);
         for (int p = 0; p < GridSide; p++) begin
            case ($urandom_range(0, 3))
               0: pool[p] = $urandom;
               1: pool[p] = directed[$urandom_range(0, 23)];
               2: pool[p] = $urandom_range(0, 3);
               default: pool[p] = (p == 0) ? value_type'($urandom)
                                           : pool[0] ^ (32'h1 << $urandom_range(0, 31));
            endcase
         end
         for (int r = 0; r < GridSide; r++) begin
            for (int c = 0; c < GridSide; c++) begin
               k = r * GridSide + c;
               case (kind)
                  0: elem = pool[$urandom_range(0, 1)];
                  1: elem = pool[$urandom_range(0, 2)];
                  2: elem = pool[0];
                  3: elem = pool[r];
                  4: elem = pool[c];
                  5: elem = pool[(c - r + GridSide) % GridSide];
                  6: elem = pool[(c + r) % GridSide];
                  default: elem = $urandom;
               endcase
               // break up patterns now and then
               if (kind != 7 && $urandom_range(0, 11) == 0) begin
                  elem = pool[$urandom_range(0, GridSide - 1)];
               end
               if (g == 0 && k < 24) begin
                  elem = directed[k];
               end
               cell_stream.push_back(elem);
            end
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      start = 0;
      for (int ph = 0; ph < Phases; ph++) begin
         sender_idle_pct   = send_pct[ph];
         receiver_idle_pct = recv_pct[ph];
         write_csr(anti_cfg[ph]);
         for (int i = start; i < phase_end[ph]; i++) begin
            pending_cells.push_back(cell_stream[i]);
         end
         start = phase_end[ph];
         wait_quiet();
      end

      if (mismatches == 0) begin
         $display("** longest_equal_run_grid_top: PASSED **");
      end else begin
         $display("** longest_equal_run_grid_top: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #(TimeoutNs);
      $display("** longest_equal_run_grid_top: FAILED **");
      $finish;
   end

endmodule
